[hw/rtl/lbtc_pkg.sv]
`default_nettype none

package lbtc_pkg;

    localparam int LINE_SIZE_DEF = 64;
    localparam int FLUSH_MARGIN  = 9;
    localparam int STOP_BITS     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CNT_W         = 4;
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_TAB     = 2'd1,
        OP_NEWLINE = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/lbtc_ram.sv]
`default_nettype none

module lbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lbtc_front.sv]
`default_nettype none

module lbtc_front
    import lbtc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              suppress,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic           keep;
    logic           push;
    cmd_t           new_cmd;

    // classify: suppressed and nul bytes never reach the queue
    always_comb
    begin
        keep       = !suppress && (char_in != CH_NUL);
        new_cmd.ch = char_in;
        case (char_in)
            CH_NL:   new_cmd.op = OP_NEWLINE;
            CH_TAB:  new_cmd.op = OP_TAB;
            default: new_cmd.op = OP_STORE;
        endcase
    end

    assign in_stall  = (cnt_reg == QCW'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (cmd_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCW'(QUEUE_DEPTH))
        else $error("queue count over depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/lbtc_back.sv]
`default_nettype none

module lbtc_back
    import lbtc_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire cmd_t              cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CHAR_W-1:0]      char_out,
    output logic                   last_of_run
);

    localparam int AW = $clog2(LINE_SIZE);
    localparam logic [AW-1:0] FLUSH_AT = AW'(LINE_SIZE - FLUSH_MARGIN);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_TAB     = 8'b0000_0010,
        S_RAW_RD  = 8'b0000_0100,
        S_RAW_EM  = 8'b0000_1000,
        S_NL_RD   = 8'b0001_0000,
        S_NL_DAT  = 8'b0010_0000,
        S_NL_EMIT = 8'b0100_0000,
        S_NL_END  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]  tabs_reg, tabs_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_out_reg;
    logic              last_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;

    logic              out_free;
    logic              emit;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_last;
    logic [AW-1:0]     filled;
    state_t            after_write;
    logic              at_stop;
    logic [CNT_W-1:0]  stop_tabs;
    logic [CNT_W-1:0]  stop_run;

    lbtc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_SIZE)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign filled   = fill_reg + AW'(1);

    // run of spaces that reaches a tab stop turns into a pending tab
    assign at_stop   = (pos_reg[STOP_BITS-1:0] == '0) && (run_reg != '0);
    assign stop_tabs = at_stop ? tabs_reg + CNT_W'(1) : tabs_reg;
    assign stop_run  = at_stop ? '0 : run_reg;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        tabs_next   = tabs_reg;
        run_next    = run_reg;
        cmd_pop     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = fill_reg;
        wr_data     = CH_SP;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        emit        = 1'b0;
        emit_char   = rd_data;
        emit_last   = 1'b0;
        after_write = (filled >= FLUSH_AT) ? S_RAW_RD : S_IDLE;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_STORE:
                        begin
                            wr_en      = 1'b1;
                            wr_data    = cmd.ch;
                            fill_next  = filled;
                            state_next = after_write;
                        end
                        OP_TAB:
                        begin
                            wr_en      = 1'b1;
                            fill_next  = filled;
                            state_next = (filled[STOP_BITS-1:0] != '0) ? S_TAB : after_write;
                        end
                        OP_NEWLINE:
                        begin
                            pos_next   = '0;
                            tabs_next  = '0;
                            run_next   = '0;
                            state_next = S_NL_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TAB:
            begin
                wr_en      = 1'b1;
                fill_next  = filled;
                state_next = (filled[STOP_BITS-1:0] != '0) ? S_TAB : after_write;
            end
            S_RAW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                pos_next   = '0;
                state_next = S_RAW_EM;
            end
            S_RAW_EM:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (pos_reg == fill_reg - AW'(1))
                    begin
                        emit_last  = 1'b1;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_reg + AW'(1);
                        pos_next = pos_reg + AW'(1);
                    end
                end
            end
            S_NL_RD:
            begin
                if (pos_reg < fill_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_NL_DAT;
                end
                else
                begin
                    state_next = S_NL_END;
                end
            end
            S_NL_DAT:
            begin
                tabs_next = stop_tabs;
                if (rd_data == CH_SP)
                begin
                    run_next   = stop_run + CNT_W'(1);
                    pos_next   = pos_reg + AW'(1);
                    state_next = S_NL_RD;
                end
                else
                begin
                    run_next   = stop_run;
                    state_next = S_NL_EMIT;
                end
            end
            S_NL_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (tabs_reg != '0)
                    begin
                        emit_char = CH_TAB;
                        tabs_next = tabs_reg - CNT_W'(1);
                    end
                    else if (run_reg != '0)
                    begin
                        emit_char = CH_SP;
                        run_next  = run_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pos_next   = pos_reg + AW'(1);
                        state_next = S_NL_RD;
                    end
                end
            end
            S_NL_END:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = CH_NL;
                    emit_last  = 1'b1;
                    fill_next  = '0;
                    tabs_next  = '0;
                    run_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            pos_reg       <= '0;
            tabs_reg      <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            tabs_reg  <= tabs_next;
            run_reg   <= run_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_out_reg <= emit_char;
            last_reg     <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign last_of_run = last_reg;

    a_idle_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> fill_reg < FLUSH_AT)
        else $error("fill at or above flush point while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tabs_reg <= CNT_W'(8) && run_reg <= CNT_W'(8))
        else $error("pending tab or space count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && out_stall))
        else $error("output register overwritten while stalled");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_last |=> fill_reg == '0 && state_reg == S_IDLE)
        else $error("run end did not clear the line");

endmodule

`default_nettype wire

[hw/rtl/line_buffer_tab_compressor_top.sv]
// channel   signals                      role
// in        in_valid in_stall            char_in, suppress
// out       out_valid out_stall          char_out, last_of_run
//
// ordinary character: one stored byte in the back end, a tab 1 to 8 stored spaces
// newline: stored bytes are read back and emitted as tabs, spaces and bytes, then a newline
// raw flush: one line ram read per output byte
// a two entry command queue lets the input side run ahead of the back end
// reset clears the fill count, the queue and the output valid; the line ram is not cleared
// out_stall holds the output register and freezes the back end when it needs to emit
`default_nettype none

module line_buffer_tab_compressor_top
    import lbtc_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              suppress,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CHAR_W-1:0]      char_out,
    output logic                   last_of_run
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    lbtc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .suppress  (suppress),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lbtc_back #(
        .LINE_SIZE (LINE_SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lbtc_pkg::*;

    localparam int LINE_SIZE    = LINE_SIZE_DEF;
    localparam int STORE_DEPTH  = 64;
    localparam int STOP_MASK    = (1 << STOP_BITS) - 1;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_end;
    } out_byte_t;

    class entab_scoreboard;
        logic [CHAR_W-1:0] line_mem [STORE_DEPTH];
        int unsigned       fill;
        out_byte_t         pending_bytes [$];
        int                errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void take_char(logic [CHAR_W-1:0] c, logic s);
            logic [CHAR_W-1:0] burst [$];
            int unsigned tabs;
            int unsigned run;
            tabs = 0;
            run  = 0;
            if (s)
                return;
            if (c == CH_NL)
            begin
                for (int unsigned p = 0; p < fill; p++)
                begin
                    if ((p & STOP_MASK) == 0 && run != 0)
                    begin
                        tabs++;
                        run = 0;
                    end
                    if (line_mem[p] == CH_SP)
                        run++;
                    else
                    begin
                        repeat (tabs) burst.push_back(CH_TAB);
                        repeat (run) burst.push_back(CH_SP);
                        tabs = 0;
                        run  = 0;
                        burst.push_back(line_mem[p]);
                    end
                end
                burst.push_back(CH_NL);
                fill = 0;
            end
            else if (c == CH_TAB)
            begin
                do
                begin
                    line_mem[fill % STORE_DEPTH] = CH_SP;
                    fill++;
                end
                while ((fill & STOP_MASK) != 0 && fill < STORE_DEPTH);
            end
            else if (c != CH_NUL)
            begin
                line_mem[fill % STORE_DEPTH] = c;
                fill++;
            end
            // raw flush near the end of the line
            if (fill >= LINE_SIZE - FLUSH_MARGIN)
            begin
                for (int unsigned p = 0; p < fill; p++)
                    burst.push_back(line_mem[p]);
                fill = 0;
            end
            foreach (burst[i])
                pending_bytes.push_back('{ch: burst[i], run_end: (i == burst.size() - 1)});
        endfunction

        function void match_byte(logic [CHAR_W-1:0] ch, logic run_end);
            out_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %0d run_end %0b, nothing pending", $time, ch,
                         run_end);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (ch !== want.ch)
            begin
                $display("%0t: char_out expected %0d got %0d", $time, want.ch, ch);
                errors++;
            end
            if (run_end !== want.run_end)
            begin
                $display("%0t: last_of_run expected %0b got %0b", $time, want.run_end, run_end);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] char_in;
    logic              suppress;
    logic              out_valid;
    logic              out_stall;
    logic [CHAR_W-1:0] char_out;
    logic              last_of_run;

    entab_scoreboard sb;
    bit              calm;
    int unsigned     counted;
    int unsigned     cycle_count;

    line_buffer_tab_compressor_top #(
        .LINE_SIZE(LINE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_in(char_in),
        .suppress(suppress),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .char_out(char_out),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_byte(char_out, last_of_run);
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic s);
        in_valid <= 1'b1;
        char_in  <= c;
        suppress <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_char(c, s);
        counted++;
        calm = (counted >= 80 && counted < 105) || counted >= 150;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_random(input bit long_line);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else if (r < 9)
            send_char(CH_NUL, 1'b0);
        else if (r < 19)
            send_char(CHAR_W'($urandom_range(1, 255)), 1'b0);
        else if (r < (long_line ? 60 : 31))
            send_char(CH_TAB, 1'b0);
        else if (r < 66)
            send_char(CH_SP, 1'b0);
        else
            send_char(CHAR_W'($urandom_range(33, 126)), 1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        string word;
        int    len;
        sb          = new();
        calm        = 1'b0;
        counted     = 0;
        cycle_count = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        char_in  <= CH_NUL;
        suppress <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty line, ignored and dropped transactions
        send_char(CH_NL, 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char("Q", 1'b1);
        send_char(CH_NL, 1'b1);
        // lone space right before a tab stop
        send_char(8'hFF, 1'b0);
        send_char(8'h01, 1'b0);
        word = "abcde";
        for (int i = 0; i < word.len(); i++)
            send_char(word[i], 1'b0);
        send_char(CH_SP, 1'b0);
        send_char("z", 1'b0);
        send_char(CH_NL, 1'b0);
        // trailing blanks
        send_char("x", 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_SP, 1'b0);
        send_char(CH_NL, 1'b0);
        // tab that crosses the flush threshold
        repeat (6) send_char(CH_TAB, 1'b0);
        send_char("a", 1'b0);
        send_char(CH_TAB, 1'b0);
        wait_drained();

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat (30) send_random(1'b1);
            else
            begin
                len = $urandom_range(0, 12);
                repeat (len) send_random(1'b0);
                send_char(CH_NL, $urandom_range(0, 99) < 3);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_bytes.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived", $time, sb.pending_bytes.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
